@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/cpcr_pkg.sv @@
// ---------------------------------------------------------------------------
// cpcr_pkg
// Shared constants and types for the circle pair collision resolver.
// ---------------------------------------------------------------------------
package cpcr_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NORM_BITS     = 30;
    localparam int SQ_W          = 66;
    localparam int DIST_W        = 34;
    localparam int NUM_W         = DIST_W + NORM_BITS;
    localparam int N_W           = 32;

    typedef enum logic [1:0] {
        OUT_COINCIDENT = 2'd0,
        OUT_IMPULSE    = 2'd1,
        OUT_SEPARATE   = 2'd2
    } outcome_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage

@@ rtl/circle_pair_collision_resolve_unit.sv @@
// ---------------------------------------------------------------------------
// circle_pair_collision_resolve_unit
// Equal-mass elastic collision of one circle pair, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Drive the pair on the input ports and raise start; the item is taken at
//   any edge with start high and busy low. busy is always low: the pipeline
//   takes a new pair every cycle.
//   Each result appears for one cycle with done high; the receiver cannot
//   stall, so nothing ever backs up.
//   Pipeline order: difference and squares, square root (one bit a stage),
//   normal x and y dividers (one bit a stage), then signed normal, products,
//   push and dot, impulse, update. Throughput one item per cycle.
//   The square root and divider chains set the latency.
//   Reset clears all valid bits; payload in flight is dropped.
//   Coincident centres pass everything through with outcome 0.
// ---------------------------------------------------------------------------
module circle_pair_collision_resolve_unit #(
    parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_pos_x,
    input  logic signed [31:0] a_pos_y,
    input  logic signed [31:0] a_vel_x,
    input  logic signed [31:0] a_vel_y,
    input  logic [23:0]        a_radius,
    input  logic signed [31:0] b_pos_x,
    input  logic signed [31:0] b_pos_y,
    input  logic signed [31:0] b_vel_x,
    input  logic signed [31:0] b_vel_y,
    input  logic [23:0]        b_radius,
    output logic               done,
    output logic signed [31:0] new_a_pos_x,
    output logic signed [31:0] new_a_pos_y,
    output logic signed [31:0] new_a_vel_x,
    output logic signed [31:0] new_a_vel_y,
    output logic signed [31:0] new_b_pos_x,
    output logic signed [31:0] new_b_pos_y,
    output logic signed [31:0] new_b_vel_x,
    output logic signed [31:0] new_b_vel_y,
    output logic [1:0]         outcome
);
`include "assert_macros.svh"
    // FRAC_BITS only sets how the raw bits are read; arithmetic is on raw values.
    localparam int NB = cpcr_pkg::NORM_BITS;
    localparam int DW = cpcr_pkg::DIST_W;

    // item context carried alongside the long chains
    typedef struct packed {
        logic signed [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
        logic [24:0]        rsum;
        logic               coin;
        logic               sx, sy;
        logic [32:0]        mx, my;
    } ctx_t;
    localparam int CW = $bits(ctx_t);

    assign busy = 1'b0;
    logic accept;
    assign accept = start && !busy;

    // stage 1: differences
    logic s1_v_reg;
    ctx_t s1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= accept;
    end
    always_ff @(posedge clk)
    begin : s1_data
        logic signed [32:0] dx, dy;
        dx = 33'(b_pos_x) - 33'(a_pos_x);
        dy = 33'(b_pos_y) - 33'(a_pos_y);
        s1_reg.apx  <= a_pos_x; s1_reg.apy <= a_pos_y;
        s1_reg.avx  <= a_vel_x; s1_reg.avy <= a_vel_y;
        s1_reg.bpx  <= b_pos_x; s1_reg.bpy <= b_pos_y;
        s1_reg.bvx  <= b_vel_x; s1_reg.bvy <= b_vel_y;
        s1_reg.rsum <= 25'(a_radius) + 25'(b_radius);
        s1_reg.coin <= (dx == '0) && (dy == '0);
        s1_reg.sx   <= dx[32];
        s1_reg.sy   <= dy[32];
        s1_reg.mx   <= dx[32] ? 33'(-dx) : 33'(dx);
        s1_reg.my   <= dy[32] ? 33'(-dy) : 33'(dy);
    end

    // stage 2: squared distance
    logic s2_v_reg;
    ctx_t s2_reg;
    logic [cpcr_pkg::SQ_W-1:0] sq_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        s2_reg <= s1_reg;
        sq_reg <= 66'(s1_reg.mx * s1_reg.mx) + 66'(s1_reg.my * s1_reg.my);
    end

    // square root
    logic          sq_v;
    logic [DW-1:0] root_dist;
    ctx_t          sq_ctx;
    cpcr_sqrt_pipe #(.TAG_W(CW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(s2_v_reg), .radicand(sq_reg),
        .in_tag(s2_reg), .out_valid(sq_v), .root(root_dist), .out_tag(sq_ctx)
    );

    // normal components; the y divider carries the context and distance
    logic [DW-1:0] dsafe;
    assign dsafe = (root_dist == '0) ? DW'(1) : root_dist;
    logic          dx_v, dy_v;
    logic [31:0]   qx, qy;
    logic [CW-1:0] tx_unused;
    logic [CW+DW-1:0] ty;
    cpcr_div_pipe #(.TAG_W(CW)) u_divx (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_v),
        .dividend(cpcr_pkg::NUM_W'(sq_ctx.mx) << NB), .divisor(dsafe),
        .in_tag(sq_ctx), .out_valid(dx_v), .quotient(qx), .out_tag(tx_unused)
    );
    cpcr_div_pipe #(.TAG_W(CW+DW)) u_divy (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_v),
        .dividend(cpcr_pkg::NUM_W'(sq_ctx.my) << NB), .divisor(dsafe),
        .in_tag({sq_ctx, root_dist}), .out_valid(dy_v), .quotient(qy), .out_tag(ty)
    );
    ctx_t          dv_ctx;
    logic [DW-1:0] dv_dist;
    assign {dv_ctx, dv_dist} = ty;

    // stage A: signed normal, overlap, relative velocity
    logic a_v_reg;
    ctx_t a_ctx_reg;
    logic signed [32:0] nx_reg, ny_reg, rvx_reg, rvy_reg;
    logic signed [35:0] ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= dy_v;
    end
    always_ff @(posedge clk)
    begin
        a_ctx_reg <= dv_ctx;
        nx_reg  <= dv_ctx.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        ny_reg  <= dv_ctx.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        ov_reg  <= $signed(36'(dv_ctx.rsum)) - $signed(36'(dv_dist));
        rvx_reg <= 33'(dv_ctx.bvx) - 33'(dv_ctx.avx);
        rvy_reg <= 33'(dv_ctx.bvy) - 33'(dv_ctx.avy);
    end

    // stage B: products
    logic b_v_reg;
    ctx_t b_ctx_reg;
    logic signed [32:0] bnx_reg, bny_reg;
    logic signed [68:0] px_reg, py_reg, dpx_reg, dpy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else
            b_v_reg <= a_v_reg;
    end
    always_ff @(posedge clk)
    begin
        b_ctx_reg <= a_ctx_reg;
        bnx_reg <= nx_reg;
        bny_reg <= ny_reg;
        px_reg  <= 69'(ov_reg) * 69'(nx_reg);
        py_reg  <= 69'(ov_reg) * 69'(ny_reg);
        dpx_reg <= 69'(rvx_reg) * 69'(nx_reg);
        dpy_reg <= 69'(rvy_reg) * 69'(ny_reg);
    end

    function automatic logic signed [68:0] tshift(input logic signed [68:0] p,
                                                  input int sh);
        logic [68:0] m;
        m = p[68] ? 69'(-p) : 69'(p);
        m = m >> sh;
        return p[68] ? -$signed(m) : $signed(m);
    endfunction

    // stage C: push, dot, v_n
    logic c_v_reg;
    ctx_t c_ctx_reg;
    logic signed [32:0] cnx_reg, cny_reg;
    logic signed [37:0] pushx_reg, pushy_reg;
    logic [37:0] vn_reg;
    logic sepr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else
            c_v_reg <= b_v_reg;
    end
    always_ff @(posedge clk)
    begin : c_data
        logic signed [69:0] dot;
        logic [69:0] dm;
        dot = 70'(dpx_reg) + 70'(dpy_reg);
        dm  = dot[69] ? 70'(-dot) : 70'(dot);
        c_ctx_reg <= b_ctx_reg;
        cnx_reg   <= bnx_reg;
        cny_reg   <= bny_reg;
        pushx_reg <= 38'(tshift(px_reg, NB + 1));
        pushy_reg <= 38'(tshift(py_reg, NB + 1));
        sepr_reg  <= !dot[69] && (dot != '0);
        vn_reg    <= 38'(dm >> NB);
    end

    // stage D: impulse products
    logic d_v_reg;
    ctx_t d_ctx_reg;
    logic signed [37:0] dpushx_reg, dpushy_reg;
    logic signed [68:0] ipx_reg, ipy_reg;
    logic dsep_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else
            d_v_reg <= c_v_reg;
    end
    always_ff @(posedge clk)
    begin
        d_ctx_reg  <= c_ctx_reg;
        dpushx_reg <= pushx_reg;
        dpushy_reg <= pushy_reg;
        dsep_reg   <= sepr_reg;
        ipx_reg    <= $signed({31'b0, vn_reg}) * 69'(cnx_reg);
        ipy_reg    <= $signed({31'b0, vn_reg}) * 69'(cny_reg);
    end

    // stage E: update, saturate, output register
    logic done_reg;
    logic signed [31:0] o_reg [8];
    logic [1:0] oc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_v_reg;
    end
    always_ff @(posedge clk)
    begin : e_data
        logic signed [68:0] ix, iy;
        ix = dsep_reg ? 69'sd0 : tshift(ipx_reg, NB);
        iy = dsep_reg ? 69'sd0 : tshift(ipy_reg, NB);
        if (d_ctx_reg.coin)
        begin
            o_reg[0] <= d_ctx_reg.apx; o_reg[1] <= d_ctx_reg.apy;
            o_reg[2] <= d_ctx_reg.avx; o_reg[3] <= d_ctx_reg.avy;
            o_reg[4] <= d_ctx_reg.bpx; o_reg[5] <= d_ctx_reg.bpy;
            o_reg[6] <= d_ctx_reg.bvx; o_reg[7] <= d_ctx_reg.bvy;
            oc_reg   <= cpcr_pkg::OUT_COINCIDENT;
        end
        else
        begin
            o_reg[0] <= cpcr_pkg::sat32(68'(d_ctx_reg.apx) - 68'(dpushx_reg));
            o_reg[1] <= cpcr_pkg::sat32(68'(d_ctx_reg.apy) - 68'(dpushy_reg));
            o_reg[2] <= cpcr_pkg::sat32(68'(d_ctx_reg.avx) - 68'(ix));
            o_reg[3] <= cpcr_pkg::sat32(68'(d_ctx_reg.avy) - 68'(iy));
            o_reg[4] <= cpcr_pkg::sat32(68'(d_ctx_reg.bpx) + 68'(dpushx_reg));
            o_reg[5] <= cpcr_pkg::sat32(68'(d_ctx_reg.bpy) + 68'(dpushy_reg));
            o_reg[6] <= cpcr_pkg::sat32(68'(d_ctx_reg.bvx) + 68'(ix));
            o_reg[7] <= cpcr_pkg::sat32(68'(d_ctx_reg.bvy) + 68'(iy));
            oc_reg   <= dsep_reg ? cpcr_pkg::OUT_SEPARATE : cpcr_pkg::OUT_IMPULSE;
        end
    end

    assign done        = done_reg;
    assign new_a_pos_x = o_reg[0];
    assign new_a_pos_y = o_reg[1];
    assign new_a_vel_x = o_reg[2];
    assign new_a_vel_y = o_reg[3];
    assign new_b_pos_x = o_reg[4];
    assign new_b_pos_y = o_reg[5];
    assign new_b_vel_x = o_reg[6];
    assign new_b_vel_y = o_reg[7];
    assign outcome     = oc_reg;

    // the two normal dividers run in lockstep
    `ASSERT_CLK(a_div_lockstep, dx_v == dy_v, "normal dividers out of step")
    // an accepted item emerges from the square root after its fixed depth
    `ASSERT_CLK(a_root_latency, s2_v_reg |-> ##33 sq_v, "root stage lost an item")
    `ASSERT_CLK(a_outcome_code, done |-> (outcome != 2'd3), "bad outcome code")
    `ASSERT_RST(a_idle_reset, !rst_n |=> !done, "result during reset")
endmodule

@@ rtl/cpcr_sqrt_pipe.sv @@
// ---------------------------------------------------------------------------
// cpcr_sqrt_pipe
// Restoring integer square root, one result bit per pipeline stage.
// ---------------------------------------------------------------------------
module cpcr_sqrt_pipe #(
    parameter int TAG_W = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [cpcr_pkg::SQ_W-1:0]       radicand,
    input  logic [TAG_W-1:0]                in_tag,
    output logic                            out_valid,
    output logic [cpcr_pkg::DIST_W-1:0]     root,
    output logic [TAG_W-1:0]                out_tag
);
    localparam int STEPS = cpcr_pkg::SQ_W / 2;
    localparam int RW    = cpcr_pkg::SQ_W;

    logic [STEPS:0]         v_reg;
    logic [RW-1:0]          rem_reg [STEPS+1];
    logic [RW-1:0]          x_reg   [STEPS+1];
    logic [STEPS-1:0]       q_reg   [STEPS+1];
    logic [TAG_W-1:0]       tag_reg [STEPS+1];

    always_comb
    begin
        rem_reg[0] = '0;
        x_reg[0]   = radicand;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
        v_reg[0]   = in_valid;
    end

    genvar s;
    generate
        for (s = 0; s < STEPS; s++)
        begin : g_step
            logic [RW+1:0] rem_next;
            logic [RW+1:0] trial;
            always_comb
            begin
                rem_next = {rem_reg[s], x_reg[s][RW-1 -: 2]};
                trial    = {{(RW-STEPS){1'b0}}, q_reg[s], 2'b01};
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s+1] <= 1'b0;
                else
                    v_reg[s+1] <= v_reg[s];
            end
            always_ff @(posedge clk)
            begin
                x_reg[s+1]   <= {x_reg[s][RW-3:0], 2'b00};
                tag_reg[s+1] <= tag_reg[s];
                if (rem_next >= trial)
                begin
                    rem_reg[s+1] <= RW'(rem_next - trial);
                    q_reg[s+1]   <= {q_reg[s][STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= RW'(rem_next);
                    q_reg[s+1]   <= {q_reg[s][STEPS-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[STEPS];
    assign root      = cpcr_pkg::DIST_W'(q_reg[STEPS]);
    assign out_tag   = tag_reg[STEPS];
endmodule

@@ rtl/cpcr_div_pipe.sv @@
// ---------------------------------------------------------------------------
// cpcr_div_pipe
// Restoring unsigned divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module cpcr_div_pipe #(
    parameter int TAG_W = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [cpcr_pkg::NUM_W-1:0]      dividend,
    input  logic [cpcr_pkg::DIST_W-1:0]     divisor,
    input  logic [TAG_W-1:0]                in_tag,
    output logic                            out_valid,
    output logic [cpcr_pkg::N_W-1:0]        quotient,
    output logic [TAG_W-1:0]                out_tag
);
    // quotient is at most 2^30, so only its low N_W bits are produced
    localparam int NW = cpcr_pkg::NUM_W;
    localparam int DW = cpcr_pkg::DIST_W;
    localparam int QW = cpcr_pkg::N_W;

    logic [QW:0]     v_reg;
    logic [NW-1:0]   rem_reg [QW+1];
    logic [DW-1:0]   d_reg   [QW+1];
    logic [QW-1:0]   q_reg   [QW+1];
    logic [TAG_W-1:0] tag_reg [QW+1];

    always_comb
    begin
        v_reg[0]   = in_valid;
        rem_reg[0] = dividend;
        d_reg[0]   = divisor;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
    end

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_step
            localparam int SH = QW - 1 - s;
            logic [NW+QW-1:0] shd;
            always_comb
                shd = {{QW{1'b0}}, d_reg[s]} << SH;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s+1] <= 1'b0;
                else
                    v_reg[s+1] <= v_reg[s];
            end
            always_ff @(posedge clk)
            begin
                d_reg[s+1]   <= d_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                if ({{QW{1'b0}}, rem_reg[s]} >= shd)
                begin
                    rem_reg[s+1] <= NW'({{QW{1'b0}}, rem_reg[s]} - shd);
                    q_reg[s+1]   <= q_reg[s] | (QW'(1) << SH);
                end
                else
                begin
                    rem_reg[s+1] <= rem_reg[s];
                    q_reg[s+1]   <= q_reg[s];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW];
    assign quotient  = q_reg[QW];
    assign out_tag   = tag_reg[QW];
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for circle_pair_collision_resolve_unit: drives circle pairs with
// random idle bursts, predicts each resolved pair in wide integer arithmetic
// and compares every result field against the oldest prediction.
// ---------------------------------------------------------------------------

typedef struct {
    logic signed [31:0] apx, apy, avx, avy;
    logic [23:0]        ar;
    logic signed [31:0] bpx, bpy, bvx, bvy;
    logic [23:0]        br;
} pair_t;

typedef struct {
    logic signed [31:0]  v [8];
    cpcr_pkg::outcome_t  oc;
} resolved_t;

class collision_scoreboard;
    resolved_t pending[$];
    int        mismatches;

    // floor square root of a value below 2^66
    static function automatic logic [33:0] root_floor(logic [65:0] s);
        logic [33:0]  r;
        logic [33:0]  c;
        logic [67:0]  sq;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c  = r | (34'd1 << b);
            sq = 68'(c) * 68'(c);
            if (sq <= 68'(s))
                r = c;
        end
        return r;
    endfunction

    // trunc(a*b / 2^sh), toward zero
    static function automatic logic signed [127:0] scale_trunc(
        logic signed [127:0] a, logic signed [127:0] b, int sh);
        logic signed [127:0] p;
        p = a * b;
        if (p < 0)
            return -((-p) >>> sh);
        return p >>> sh;
    endfunction

    static function automatic logic signed [31:0] clamp(logic signed [127:0] x);
        if (x > 128'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -128'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function void note_pair(pair_t p);
        resolved_t           r;
        logic signed [127:0] dx, dy, cdist, nx, ny, ov, px, py, rvx, rvy, dot, vn, ix, iy;
        logic signed [127:0] avx, avy, bvx, bvy;
        logic [65:0]         sq;
        dx = 128'(p.bpx) - 128'(p.apx);
        dy = 128'(p.bpy) - 128'(p.apy);
        avx = p.avx; avy = p.avy; bvx = p.bvx; bvy = p.bvy;
        if (dx == 0 && dy == 0)
        begin
            r.v = '{p.apx, p.apy, p.avx, p.avy, p.bpx, p.bpy, p.bvx, p.bvy};
            r.oc = cpcr_pkg::OUT_COINCIDENT;
            pending.push_back(r);
            return;
        end
        sq    = 66'(dx * dx + dy * dy);
        cdist = 128'(root_floor(sq));
        nx = ((dx < 0 ? -dx : dx) <<< cpcr_pkg::NORM_BITS) / cdist;
        if (dx < 0) nx = -nx;
        ny = ((dy < 0 ? -dy : dy) <<< cpcr_pkg::NORM_BITS) / cdist;
        if (dy < 0) ny = -ny;
        ov = 128'(p.ar) + 128'(p.br) - cdist;
        px = scale_trunc(ov, nx, cpcr_pkg::NORM_BITS + 1);
        py = scale_trunc(ov, ny, cpcr_pkg::NORM_BITS + 1);
        rvx = bvx - avx;
        rvy = bvy - avy;
        dot = rvx * nx + rvy * ny;
        if (dot > 0)
            r.oc = cpcr_pkg::OUT_SEPARATE;
        else
        begin
            vn = (-dot) >>> cpcr_pkg::NORM_BITS;
            ix = scale_trunc(vn, nx, cpcr_pkg::NORM_BITS);
            iy = scale_trunc(vn, ny, cpcr_pkg::NORM_BITS);
            avx -= ix; avy -= iy; bvx += ix; bvy += iy;
            r.oc = cpcr_pkg::OUT_IMPULSE;
        end
        r.v[0] = clamp(128'(p.apx) - px);
        r.v[1] = clamp(128'(p.apy) - py);
        r.v[2] = clamp(avx);
        r.v[3] = clamp(avy);
        r.v[4] = clamp(128'(p.bpx) + px);
        r.v[5] = clamp(128'(p.bpy) + py);
        r.v[6] = clamp(bvx);
        r.v[7] = clamp(bvy);
        pending.push_back(r);
    endfunction

    function void check_result(resolved_t got);
        resolved_t exp_r;
        bit        bad;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result at %0t", $time);
            return;
        end
        exp_r = pending.pop_front();
        bad = (got.oc !== exp_r.oc);
        for (int k = 0; k < 8; k++)
            if (got.v[k] !== exp_r.v[k])
                bad = 1;
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at %0t: outcome exp %0d got %0d", $time, exp_r.oc, got.oc);
                for (int k = 0; k < 8; k++)
                    $display("  field %0d exp %0d got %0d", k, exp_r.v[k], got.v[k]);
            end
        end
    endfunction
endclass

module tb;
    localparam int LATENCY = 72;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] a_pos_x = '0, a_pos_y = '0, a_vel_x = '0, a_vel_y = '0;
    logic [23:0]        a_radius = '0;
    logic signed [31:0] b_pos_x = '0, b_pos_y = '0, b_vel_x = '0, b_vel_y = '0;
    logic [23:0]        b_radius = '0;
    logic               done;
    logic signed [31:0] new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y;
    logic signed [31:0] new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y;
    logic [1:0]         outcome;

    collision_scoreboard sb = new();
    bit                  quiet_tail;

    circle_pair_collision_resolve_unit u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // results cannot be held off: take every done cycle
    always @(posedge clk)
    begin
        resolved_t r;
        if (rst_n && done)
        begin
            r.v = '{new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
                    new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y};
            r.oc = cpcr_pkg::outcome_t'(outcome);
            sb.check_result(r);
        end
    end

    // present one pair and hold it until an edge takes it
    task automatic send_pair(pair_t p);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        a_pos_x  <= p.apx; a_pos_y <= p.apy; a_vel_x <= p.avx; a_vel_y <= p.avy;
        a_radius <= p.ar;
        b_pos_x  <= p.bpx; b_pos_y <= p.bpy; b_vel_x <= p.bvx; b_vel_y <= p.bvy;
        b_radius <= p.br;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_pair(p);
    endtask

    function automatic logic signed [31:0] rnd32();
        return $urandom();
    endfunction

    // mostly near neighbours with modest speeds, sometimes anything at all or coincident centres
    function automatic pair_t random_pair();
        pair_t p;
        int    mode;
        mode = $urandom_range(0, 9);
        p.apx = rnd32(); p.apy = rnd32();
        p.avx = rnd32(); p.avy = rnd32();
        p.bvx = rnd32(); p.bvy = rnd32();
        p.ar = 24'($urandom()); p.br = 24'($urandom());
        if (mode < 6)
        begin
            p.bpx = p.apx + $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF;
            p.bpy = p.apy + $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF;
            p.avx = p.avx >>> 8; p.avy = p.avy >>> 8;
            p.bvx = p.bvx >>> 8; p.bvy = p.bvy >>> 8;
        end
        else if (mode < 9)
        begin
            p.bpx = rnd32(); p.bpy = rnd32();
        end
        else
        begin
            p.bpx = p.apx; p.bpy = p.apy;
        end
        return p;
    endfunction

    initial
    begin
        pair_t          directed[$];
        logic signed [31:0] mx, mn;
        int             waited;
        mx = 32'sh7FFFFFFF;
        mn = 32'sh80000000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coincident centres
        directed.push_back('{100, 200, 5, 6, 24'h10000, 100, 200, 7, 8, 24'h10000});
        // overlapping and closing: impulse
        directed.push_back('{0, 0, 32'sh10000, 0, 24'h10000, 32'sh18000, 0, -32'sh10000, 0,
                             24'h10000});
        // overlapping, moving apart
        directed.push_back('{0, 0, -32'sh10000, 0, 24'h10000, 32'sh18000, 0, 32'sh10000, 0,
                             24'h10000});
        // apart: drawn together
        directed.push_back('{0, 0, 0, 0, 24'd0, 32'sh100000, 32'sh100000, 0, 0, 24'd0});
        // zero normal velocity
        directed.push_back('{0, 0, 3, 3, 24'hFFFFFF, 0, 32'sh20000, 3, 3, 24'hFFFFFF});
        // extreme separations and saturating velocities
        directed.push_back('{mn, mn, mx, mx, 24'hFFFFFF, mx, mx, mn, mn, 24'hFFFFFF});
        directed.push_back('{mx, mn, mn, mx, 24'hFFFFFF, mn, mx, mx, mn, 24'hFFFFFF});
        directed.push_back('{mx, 0, mn, 0, 24'hFFFFFF, mx - 1, 0, mx, 0, 24'hFFFFFF});
        directed.push_back('{0, mn, 0, mx, 24'd0, 0, mn + 1, 0, mn, 24'd0});
        directed.push_back('{-1, -1, -1, -1, 24'hFFFFFF, 0, 0, 0, 0, 24'hFFFFFF});
        directed.push_back('{mx, mx, mx, mx, 24'hFFFFFF, mx, mx, mn, mn, 24'hFFFFFF});
        foreach (directed[i])
            send_pair(directed[i]);

        for (int n = 0; n < 1050; n++)
        begin
            quiet_tail = (n >= 900);
            // hold off once until the pipeline has drained
            if (n == 500)
            begin
                start <= 1'b0;
                waited = 0;
                while (sb.pending.size() != 0 && waited < 1000)
                begin
                    @(posedge clk);
                    waited++;
                end
            end
            send_pair(random_pair());
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 4 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/cpcr_pkg.sv
rtl/cpcr_sqrt_pipe.sv
rtl/cpcr_div_pipe.sv
rtl/circle_pair_collision_resolve_unit.sv
sim/tb.sv
